@@ rtl/rbsh_pkg.sv @@
// shared constants for the ray versus box slab hit unit
package rbsh_pkg;

    // default coordinate format, signed fixed point
    localparam int CoordBitsDef = 32;
    localparam int FracBitsDef  = 16;

    // depth of the queue between front and back
    localparam int QueueDepth = 2;

endpackage

@@ rtl/rbsh_front.sv @@
// front part: slab offsets, direction magnitudes and parallel-axis classification
module rbsh_front
    import rbsh_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef
) (
    input  logic signed [COORD_BITS-1:0] i_origin_x,
    input  logic signed [COORD_BITS-1:0] i_origin_y,
    input  logic signed [COORD_BITS-1:0] i_dir_x,
    input  logic signed [COORD_BITS-1:0] i_dir_y,
    input  logic signed [COORD_BITS-1:0] i_box_x,
    input  logic signed [COORD_BITS-1:0] i_box_y,
    input  logic        [COORD_BITS-2:0] i_box_w,
    input  logic        [COORD_BITS-2:0] i_box_h,
    output logic signed [COORD_BITS+1:0] o_n1x,
    output logic signed [COORD_BITS+1:0] o_n2x,
    output logic signed [COORD_BITS+1:0] o_n1y,
    output logic signed [COORD_BITS+1:0] o_n2y,
    output logic        [COORD_BITS-1:0] o_adx,
    output logic        [COORD_BITS-1:0] o_ady,
    output logic                         o_sdx,
    output logic                         o_sdy,
    output logic                         o_parx,
    output logic                         o_pary,
    output logic                         o_pmiss
);
    localparam int C = COORD_BITS;

    logic signed [C:0]   far_x;
    logic signed [C:0]   far_y;
    logic signed [C:0]   ox_w;
    logic signed [C:0]   oy_w;
    logic                miss_x;
    logic                miss_y;

    // far edges, exact and one bit wider
    assign far_x = {i_box_x[C-1], i_box_x} + {2'b00, i_box_w};
    assign far_y = {i_box_y[C-1], i_box_y} + {2'b00, i_box_h};
    assign ox_w  = {i_origin_x[C-1], i_origin_x};
    assign oy_w  = {i_origin_y[C-1], i_origin_y};

    // numerators of the slab divisions
    assign o_n1x = {{2{i_box_x[C-1]}}, i_box_x} - {ox_w[C], ox_w};
    assign o_n2x = {far_x[C], far_x} - {ox_w[C], ox_w};
    assign o_n1y = {{2{i_box_y[C-1]}}, i_box_y} - {oy_w[C], oy_w};
    assign o_n2y = {far_y[C], far_y} - {oy_w[C], oy_w};

    // direction sign and magnitude
    assign o_sdx = i_dir_x[C-1];
    assign o_sdy = i_dir_y[C-1];
    assign o_adx = i_dir_x[C-1] ? C'(-i_dir_x) : i_dir_x;
    assign o_ady = i_dir_y[C-1] ? C'(-i_dir_y) : i_dir_y;

    // parallel axes: miss when the origin lies outside the slab
    assign o_parx = (i_dir_x == '0);
    assign o_pary = (i_dir_y == '0);
    assign miss_x = o_parx && ((i_origin_x < i_box_x) || (ox_w > far_x));
    assign miss_y = o_pary && ((i_origin_y < i_box_y) || (oy_w > far_y));
    assign o_pmiss = miss_x || miss_y;

endmodule

@@ rtl/rbsh_queue.sv @@
// short queue between the front and back parts
module rbsh_queue
    import rbsh_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);
    localparam int PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CW = $clog2(QueueDepth + 1);

    logic [WIDTH-1:0] r_mem [QueueDepth];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    n_wr;
    logic [PW-1:0]    r_rd;
    logic [PW-1:0]    n_rd;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(QueueDepth));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/rbsh_div.sv @@
// pipelined fixed-point divider, one quotient bit per stage, saturating
module rbsh_div
    import rbsh_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic                         i_clk,
    input  logic signed [COORD_BITS+1:0] i_num,
    input  logic        [COORD_BITS-1:0] i_den,
    input  logic                         i_den_neg,
    output logic signed [COORD_BITS-1:0] o_quot
);
    localparam int C  = COORD_BITS;
    localparam int CW = 2 * C + FRAC_BITS + 1;

    // operand stage
    logic [C:0]   r_un;
    logic [C-1:0] r_ud_a;
    logic         r_neg_a;

    // long division stages
    logic [C-1:0] r_rem [C+1];
    logic [C-1:0] r_low [C+1];
    logic [C-1:0] r_q   [C+1];
    logic [C-1:0] r_ud  [C+1];
    logic         r_neg [C+1];
    logic         r_sat [C+1];

    logic [CW-1:0] nx;
    logic [CW-1:0] dx;
    logic [C-1:0]  lim;
    logic [C-1:0]  qm;

    // magnitudes and result sign
    always_ff @(posedge i_clk) begin
        r_un    <= i_num[C+1] ? (C+1)'(-i_num) : i_num[C:0];
        r_ud_a  <= i_den;
        r_neg_a <= i_num[C+1] ^ i_den_neg;
    end

    // overflow check and first partial remainder
    assign nx = CW'(r_un) << FRAC_BITS;
    assign dx = CW'(r_ud_a) << C;

    always_ff @(posedge i_clk) begin
        r_sat[0] <= (nx >= dx);
        r_rem[0] <= nx[2*C-1:C];
        r_low[0] <= nx[C-1:0];
        r_q[0]   <= '0;
        r_ud[0]  <= r_ud_a;
        r_neg[0] <= r_neg_a;
    end

    // restoring steps
    for (genvar k = 0; k < C; k++) begin : g_step
        logic [C:0] part;
        logic [C:0] diff;
        logic       ge;

        assign part = {r_rem[k], r_low[k][C-1]};
        assign diff = part - {1'b0, r_ud[k]};
        assign ge   = (part >= {1'b0, r_ud[k]});

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= ge ? diff[C-1:0] : part[C-1:0];
            r_low[k+1] <= r_low[k] << 1;
            r_q[k+1]   <= {r_q[k][C-2:0], ge};
            r_ud[k+1]  <= r_ud[k];
            r_neg[k+1] <= r_neg[k];
            r_sat[k+1] <= r_sat[k];
        end
    end

    // clamp to the signed range and apply the sign
    assign lim = r_neg[C] ? (C'(1) << (C - 1)) : ((C'(1) << (C - 1)) - 1'b1);
    assign qm  = (r_sat[C] || (r_q[C] > lim)) ? lim : r_q[C];

    always_ff @(posedge i_clk) begin
        o_quot <= r_neg[C] ? C'(-qm) : qm;
    end

endmodule

@@ rtl/rbsh_back.sv @@
// back part: slab divisions, interval fold and entry point
module rbsh_back
    import rbsh_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS+1:0] i_n1x,
    input  logic signed [COORD_BITS+1:0] i_n2x,
    input  logic signed [COORD_BITS+1:0] i_n1y,
    input  logic signed [COORD_BITS+1:0] i_n2y,
    input  logic        [COORD_BITS-1:0] i_adx,
    input  logic        [COORD_BITS-1:0] i_ady,
    input  logic                         i_sdx,
    input  logic                         i_sdy,
    input  logic                         i_parx,
    input  logic                         i_pary,
    input  logic                         i_pmiss,
    input  logic signed [COORD_BITS-1:0] i_ox,
    input  logic signed [COORD_BITS-1:0] i_oy,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_hit_x,
    output logic signed [COORD_BITS-1:0] o_hit_y
);
    localparam int C  = COORD_BITS;
    localparam int DL = C + 3;
    localparam int MW = 4 * C + 5;
    localparam int PW = 2 * C - 1;

    // sideband that travels alongside the dividers
    logic [MW-1:0] r_meta [DL];
    logic          r_mval [DL];

    logic signed [C-1:0] t1x;
    logic signed [C-1:0] t2x;
    logic signed [C-1:0] t1y;
    logic signed [C-1:0] t2y;

    rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_1x (
        .i_clk(i_clk), .i_num(i_n1x), .i_den(i_adx), .i_den_neg(i_sdx), .o_quot(t1x));
    rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_2x (
        .i_clk(i_clk), .i_num(i_n2x), .i_den(i_adx), .i_den_neg(i_sdx), .o_quot(t2x));
    rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_1y (
        .i_clk(i_clk), .i_num(i_n1y), .i_den(i_ady), .i_den_neg(i_sdy), .o_quot(t1y));
    rbsh_div #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_div_2y (
        .i_clk(i_clk), .i_num(i_n2y), .i_den(i_ady), .i_den_neg(i_sdy), .o_quot(t2y));

    always_ff @(posedge i_clk) begin
        r_meta[0] <= {i_ox, i_oy, i_adx, i_ady, i_sdx, i_sdy, i_parx, i_pary, i_pmiss};
        for (int k = 1; k < DL; k++) begin
            r_meta[k] <= r_meta[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_mval[k] <= 1'b0;
            end
        end else begin
            r_mval[0] <= i_valid;
            for (int k = 1; k < DL; k++) begin
                r_mval[k] <= r_mval[k-1];
            end
        end
    end

    // fold the slab intervals into tmin and tmax
    logic                m_parx;
    logic                m_pary;
    logic signed [C-1:0] lox;
    logic signed [C-1:0] hix;
    logic signed [C-1:0] loy;
    logic signed [C-1:0] hiy;
    logic signed [C-1:0] tmin;
    logic signed [C-1:0] tmax;

    assign m_parx = r_meta[DL-1][2];
    assign m_pary = r_meta[DL-1][1];
    assign lox = (t1x < t2x) ? t1x : t2x;
    assign hix = (t1x < t2x) ? t2x : t1x;
    assign loy = (t1y < t2y) ? t1y : t2y;
    assign hiy = (t1y < t2y) ? t2y : t1y;

    always_comb begin
        tmin = '0;
        tmax = {1'b0, {(C-1){1'b1}}};
        if (!m_parx && (lox > tmin)) begin
            tmin = lox;
        end
        if (!m_pary && (loy > tmin)) begin
            tmin = loy;
        end
        if (!m_parx && (hix < tmax)) begin
            tmax = hix;
        end
        if (!m_pary && (hiy < tmax)) begin
            tmax = hiy;
        end
    end

    logic                r1_valid;
    logic signed [C-1:0] r1_tmin;
    logic signed [C-1:0] r1_tmax;
    logic [MW-1:0]       r1_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= r_mval[DL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r1_tmin <= tmin;
        r1_tmax <= tmax;
        r1_meta <= r_meta[DL-1];
    end

    // hit decision and scaled advance products
    logic signed [C-1:0] s_ox;
    logic signed [C-1:0] s_oy;
    logic [C-1:0]        s_adx;
    logic [C-1:0]        s_ady;
    logic                s_sdx;
    logic                s_sdy;
    logic                s_pmiss;

    assign {s_ox, s_oy, s_adx, s_ady, s_sdx, s_sdy} = r1_meta[MW-1:3];
    assign s_pmiss = r1_meta[0];

    logic                r2_valid;
    logic                r2_hit;
    logic [PW-1:0]       r2_px;
    logic [PW-1:0]       r2_py;
    logic signed [C-1:0] r2_ox;
    logic signed [C-1:0] r2_oy;
    logic                r2_sdx;
    logic                r2_sdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_hit <= !s_pmiss && (r1_tmin <= r1_tmax);
        r2_px  <= PW'(r1_tmin[C-2:0]) * PW'(s_adx);
        r2_py  <= PW'(r1_tmin[C-2:0]) * PW'(s_ady);
        r2_ox  <= s_ox;
        r2_oy  <= s_oy;
        r2_sdx <= s_sdx;
        r2_sdy <= s_sdy;
    end

    // origin plus capped step, saturated to the coordinate range
    function automatic logic signed [C-1:0] step_sat(
        input logic signed [C-1:0] org,
        input logic [PW-1:0]       prod,
        input logic                neg
    );
        logic [PW-1:0]       sh;
        logic [C+1:0]        mag;
        logic signed [C+2:0] sum;
        logic signed [C+2:0] top;
        logic signed [C+2:0] bot;
        sh  = prod >> FRAC_BITS;
        mag = (sh > PW'((C+2)'(1) << (C + 1))) ? ((C+2)'(1) << (C + 1)) : sh[C+1:0];
        top = (C+3)'({1'b0, {(C-1){1'b1}}});
        bot = -top - 1'b1;
        if (neg) begin
            sum = (C+3)'(org) - $signed({1'b0, mag});
        end else begin
            sum = (C+3)'(org) + $signed({1'b0, mag});
        end
        if (sum > top) begin
            step_sat = top[C-1:0];
        end else if (sum < bot) begin
            step_sat = bot[C-1:0];
        end else begin
            step_sat = sum[C-1:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_hit   <= 1'b0;
        end else begin
            o_valid <= r2_valid;
            o_hit   <= r2_valid && r2_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit_x <= r2_hit ? step_sat(r2_ox, r2_px, r2_sdx) : '0;
        o_hit_y <= r2_hit ? step_sat(r2_oy, r2_py, r2_sdy) : '0;
    end

endmodule

@@ rtl/ray_box_slab_hit_unit.sv @@
// top level of the ray versus box slab hit unit
//
// Tests a 2D ray against an axis-aligned box in signed fixed point and
// returns the hit flag and entry point. One item is taken every clock
// cycle while busy is low. Each item passes through the queue, the
// one-bit-per-stage slab dividers, the fold register and the hit
// register before o_valid is registered. Results cannot be held off, so
// o_valid must be taken whenever it is high. busy only rises if the
// queue between front and back fills, which the back part, taking one
// entry every cycle, does not allow in normal operation.
module ray_box_slab_hit_unit
    import rbsh_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_origin_x,
    input  logic signed [COORD_BITS-1:0] i_origin_y,
    input  logic signed [COORD_BITS-1:0] i_dir_x,
    input  logic signed [COORD_BITS-1:0] i_dir_y,
    input  logic signed [COORD_BITS-1:0] i_box_x,
    input  logic signed [COORD_BITS-1:0] i_box_y,
    input  logic        [COORD_BITS-2:0] i_box_w,
    input  logic        [COORD_BITS-2:0] i_box_h,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic signed [COORD_BITS-1:0] o_hit_x,
    output logic signed [COORD_BITS-1:0] o_hit_y
);
    localparam int C  = COORD_BITS;
    localparam int QW = 8 * C + 13;

    logic signed [C+1:0] f_n1x;
    logic signed [C+1:0] f_n2x;
    logic signed [C+1:0] f_n1y;
    logic signed [C+1:0] f_n2y;
    logic [C-1:0]        f_adx;
    logic [C-1:0]        f_ady;
    logic                f_sdx;
    logic                f_sdy;
    logic                f_parx;
    logic                f_pary;
    logic                f_pmiss;

    logic signed [C+1:0] b_n1x;
    logic signed [C+1:0] b_n2x;
    logic signed [C+1:0] b_n1y;
    logic signed [C+1:0] b_n2y;
    logic [C-1:0]        b_adx;
    logic [C-1:0]        b_ady;
    logic                b_sdx;
    logic                b_sdy;
    logic                b_parx;
    logic                b_pary;
    logic                b_pmiss;
    logic signed [C-1:0] b_ox;
    logic signed [C-1:0] b_oy;

    logic [QW-1:0] q_in;
    logic [QW-1:0] q_out;
    logic          q_empty;
    logic          q_full;
    logic          take;

    // front: classify the incoming item
    rbsh_front #(.COORD_BITS(C)) u_front (
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_box_x    (i_box_x),
        .i_box_y    (i_box_y),
        .i_box_w    (i_box_w),
        .i_box_h    (i_box_h),
        .o_n1x      (f_n1x),
        .o_n2x      (f_n2x),
        .o_n1y      (f_n1y),
        .o_n2y      (f_n2y),
        .o_adx      (f_adx),
        .o_ady      (f_ady),
        .o_sdx      (f_sdx),
        .o_sdy      (f_sdy),
        .o_parx     (f_parx),
        .o_pary     (f_pary),
        .o_pmiss    (f_pmiss)
    );

    // queue between front and back
    assign busy = q_full;
    assign take = start && !busy;
    assign q_in = {f_n1x, f_n2x, f_n1y, f_n2y, f_adx, f_ady, f_sdx, f_sdy,
                   f_parx, f_pary, f_pmiss, i_origin_x, i_origin_y};

    rbsh_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (q_in),
        .i_pop   (!q_empty),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_n1x, b_n2x, b_n1y, b_n2y, b_adx, b_ady, b_sdx, b_sdy,
            b_parx, b_pary, b_pmiss, b_ox, b_oy} = q_out;

    // back: divisions, fold and entry point
    rbsh_back #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_n1x   (b_n1x),
        .i_n2x   (b_n2x),
        .i_n1y   (b_n1y),
        .i_n2y   (b_n2y),
        .i_adx   (b_adx),
        .i_ady   (b_ady),
        .i_sdx   (b_sdx),
        .i_sdy   (b_sdy),
        .i_parx  (b_parx),
        .i_pary  (b_pary),
        .i_pmiss (b_pmiss),
        .i_ox    (b_ox),
        .i_oy    (b_oy),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y)
    );

endmodule

@@ rtl/rbsh_checker.sv @@
// port-level checks for the ray versus box slab hit unit, with bind
module rbsh_checker
    import rbsh_pkg::*;
#(
    parameter int COORD_BITS = CoordBitsDef
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         busy,
    input logic                         o_valid,
    input logic                         o_hit,
    input logic signed [COORD_BITS-1:0] o_hit_x,
    input logic signed [COORD_BITS-1:0] o_hit_y
);

    // no result strobe right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // a miss carries zero coordinates
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == '0 && o_hit_y == '0))
        else $error("miss with non-zero coordinates");

    // hit only shown with a transfer
    a_hit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_valid)
        else $error("hit flag without strobe");

    // the back part drains the queue every cycle, so it never fills
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue filled up");

endmodule

bind ray_box_slab_hit_unit rbsh_checker #(.COORD_BITS(COORD_BITS)) u_rbsh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .busy    (busy),
    .o_valid (o_valid),
    .o_hit   (o_hit),
    .o_hit_x (o_hit_x),
    .o_hit_y (o_hit_y)
);

@@ bench/tb_ray_box_slab_hit_unit.sv @@
// self-checking bench for the ray versus box slab hit unit
module tb_ray_box_slab_hit_unit;
    import rbsh_pkg::*;

    localparam int CB = CoordBitsDef;
    localparam int FB = FracBitsDef;
    localparam int PIPE_LAT = CB + 7;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_RAYS = 750;

    typedef struct {
        logic signed [CB-1:0] ox, oy, dx, dy, bx, by;
        logic        [CB-2:0] bw, bh;
    } ray_box_t;

    typedef struct {
        logic                 hit;
        logic signed [CB-1:0] hx, hy;
    } hit_point_t;

    // holds the predicted hit points in transfer order
    class hit_scoreboard;
        hit_point_t pending[$];
        int         errors;
        int         hits_seen;
        int         misses_seen;

        function longint sat_coord(longint v);
            longint top;
            top = (longint'(1) <<< (CB - 1)) - 1;
            if (v > top) return top;
            if (v < -top - 1) return -top - 1;
            return v;
        endfunction

        // (n << FB) / d truncated toward zero, saturated
        function longint slab_t(longint n, longint d);
            bit                   neg;
            longint unsigned      un, ud, lim, q;
            neg = (n < 0) != (d < 0);
            un  = (n < 0) ? -n : n;
            ud  = (d < 0) ? -d : d;
            lim = neg ? (64'd1 << (CB - 1)) : (64'd1 << (CB - 1)) - 1;
            q   = (un << FB) / ud;
            if (q > lim) q = lim;
            return neg ? -longint'(q) : longint'(q);
        endfunction

        // origin moved along the direction by t, saturated
        function longint step_along(longint o, longint t, longint d);
            longint unsigned ud, mag, cap;
            ud  = (d < 0) ? -d : d;
            cap = 64'd1 << (CB + 1);
            mag = (longint'(t) * ud) >> FB;
            if (mag > cap) mag = cap;
            return sat_coord((d < 0) ? o - longint'(mag) : o + longint'(mag));
        endfunction

        function bit slab_pass(longint o, longint d, longint edge_lo, longint ext,
                               inout longint tmin, inout longint tmax);
            longint far_edge, t1, t2, tmp;
            far_edge = edge_lo + ext;
            if (d == 0) return !(o < edge_lo || o > far_edge);
            t1 = slab_t(edge_lo - o, d);
            t2 = slab_t(far_edge - o, d);
            if (t1 > t2) begin
                tmp = t1; t1 = t2; t2 = tmp;
            end
            if (t1 > tmin) tmin = t1;
            if (t2 < tmax) tmax = t2;
            return tmin <= tmax;
        endfunction

        // work out the hit point of one accepted transfer
        function void note_transfer(ray_box_t r);
            longint     ox, oy, dx, dy, tmin, tmax;
            hit_point_t e;
            ox = longint'(r.ox); oy = longint'(r.oy);
            dx = longint'(r.dx); dy = longint'(r.dy);
            tmin = 0;
            tmax = (longint'(1) <<< (CB - 1)) - 1;
            e = '{hit: 1'b0, hx: '0, hy: '0};
            if (slab_pass(ox, dx, longint'(r.bx), longint'({1'b0, r.bw}), tmin, tmax) &&
                slab_pass(oy, dy, longint'(r.by), longint'({1'b0, r.bh}), tmin, tmax))
            begin
                e.hit = 1'b1;
                e.hx  = step_along(ox, tmin, dx);
                e.hy  = step_along(oy, tmin, dy);
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic hit, logic signed [CB-1:0] hx,
                                   logic signed [CB-1:0] hy);
            hit_point_t e;
            if (pending.size() == 0) begin
                $error("result with nothing pending: hit=%0b x=%0d y=%0d", hit, hx, hy);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hit) hits_seen++; else misses_seen++;
            if (hit !== e.hit) begin
                $error("hit: expected %0b, got %0b", e.hit, hit);
                errors++;
            end
            if (hx !== e.hx) begin
                $error("hit_x: expected %0d, got %0d", e.hx, hx);
                errors++;
            end
            if (hy !== e.hy) begin
                $error("hit_y: expected %0d, got %0d", e.hy, hy);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CB-1:0] i_origin_x, i_origin_y, i_dir_x, i_dir_y, i_box_x, i_box_y;
    logic        [CB-2:0] i_box_w, i_box_h;
    logic                 o_valid;
    logic                 o_hit;
    logic signed [CB-1:0] o_hit_x, o_hit_y;

    hit_scoreboard sb;
    int            cycles;
    int            idle_pct;
    int            rays_sent;

    ray_box_slab_hit_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_origin_x(i_origin_x),
        .i_origin_y(i_origin_y),
        .i_dir_x   (i_dir_x),
        .i_dir_y   (i_dir_y),
        .i_box_x   (i_box_x),
        .i_box_y   (i_box_y),
        .i_box_w   (i_box_w),
        .i_box_h   (i_box_h),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_hit_x   (o_hit_x),
        .o_hit_y   (o_hit_y)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_hit, o_hit_x, o_hit_y);
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // one transfer, then an optional idle gap
    task automatic send_ray(ray_box_t r);
        int gap;
        start      <= 1'b1;
        i_origin_x <= r.ox; i_origin_y <= r.oy;
        i_dir_x    <= r.dx; i_dir_y    <= r.dy;
        i_box_x    <= r.bx; i_box_y    <= r.by;
        i_box_w    <= r.bw; i_box_h    <= r.bh;
        do @(posedge i_clk); while (busy);
        sb.note_transfer(r);
        rays_sent++;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(4, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [CB-1:0] near_val(int span);
        return $signed(CB'($urandom_range(2 * span))) - span;
    endfunction

    // mostly rays aimed near a small box, some pure noise
    function automatic ray_box_t rand_ray();
        ray_box_t r;
        int       k;
        k = $urandom_range(9);
        if (k < 2) begin
            r.ox = $urandom(); r.oy = $urandom(); r.dx = $urandom(); r.dy = $urandom();
            r.bx = $urandom(); r.by = $urandom(); r.bw = $urandom(); r.bh = $urandom();
        end else begin
            r.bx = near_val(20 << FB);
            r.by = near_val(20 << FB);
            r.bw = $urandom_range(8 << FB);
            r.bh = $urandom_range(8 << FB);
            r.ox = near_val(40 << FB);
            r.oy = near_val(40 << FB);
            r.dx = (r.bx + (r.bw >> 1) - r.ox) >>> $urandom_range(6);
            r.dy = (r.by + (r.bh >> 1) - r.oy) >>> $urandom_range(6);
            r.dx = r.dx + near_val(1 << FB);
            r.dy = r.dy + near_val(1 << FB);
            if (k == 2) r.dx = '0;
            if (k == 3) r.dy = '0;
            if (k == 4) r.dx = $urandom_range(3);
            if (k == 5) r.ox = $urandom();
        end
        return r;
    endfunction

    initial begin
        ray_box_t d[$];
        ray_box_t r;
        sb = new();
        cycles = 0;
        rays_sent = 0;
        idle_pct = 0;
        start = 1'b0;
        i_origin_x = '0; i_origin_y = '0; i_dir_x = '0; i_dir_y = '0;
        i_box_x = '0; i_box_y = '0; i_box_w = '0; i_box_h = '0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed cases: zeros, origin inside, parallel edges, ties, extremes
        d.push_back('{0, 0, 0, 0, 0, 0, 0, 0});
        d.push_back('{2 << FB, 2 << FB, 1 << FB, -1 << FB, 0, 0, 5 << FB, 5 << FB});
        d.push_back('{0, 3 << FB, 1 << FB, 0, 5 << FB, 0, 1 << FB, 3 << FB});
        d.push_back('{0, 3 << FB, 0, 1 << FB, 0, 5 << FB, 4 << FB, 1 << FB});
        d.push_back('{0, 4 << FB, 1 << FB, 0, 5 << FB, 0, 1 << FB, 3 << FB});
        d.push_back('{0, 0, 1 << FB, 1 << FB, 2 << FB, -4 << FB, 2 << FB, 6 << FB});
        d.push_back('{0, 0, 1 << FB, 1 << FB, 2 << FB, -2 << FB, 3 << FB, 4 << FB});
        d.push_back('{-10 << FB, -10 << FB, 1 << FB, 1 << FB, 0, 0, 1 << FB, 1 << FB});
        d.push_back('{10 << FB, 10 << FB, -1 << FB, -1 << FB, 0, 0, 1 << FB, 1 << FB});
        d.push_back('{32'sh8000_0000, 0, 1, 0, 32'sh7fff_0000, -5, '1, 10});
        d.push_back('{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh8000_0000, '1, '1});
        d.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                      32'sh7fff_ffff, 32'sh7fff_ffff, '1, '1});
        d.push_back('{0, 0, 1, 1, 32'sh7000_0000, 32'sh7000_0000, '1, '1});
        d.push_back('{0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh4000_0000,
                      32'sh4000_0000, '1, '1});
        d.push_back('{0, 0, -1, -1, 32'sh8000_0000, 32'sh8000_0000, 10, 10});
        d.push_back('{5 << FB, 5 << FB, 1 << FB, 1 << FB, 0, 0, 2 << FB, 2 << FB});
        d.push_back('{0, 0, 0, 0, 1, 1, 5, 5});
        d.push_back('{-1, -1, 3, 7, 0, 0, 0, 0});
        foreach (d[i]) send_ray(d[i]);

        // random rays in idle phases
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: idle_pct = 0;
                1: idle_pct = 50;
                2: idle_pct = 18;
                default: idle_pct = 0;
            endcase
            repeat (RANDOM_RAYS / 4) begin
                r = rand_ray();
                send_ray(r);
            end
        end
        start <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 10) @(posedge i_clk);

        $display("sent %0d rays against boxes; %0d hits and %0d misses checked",
                 rays_sent, sb.hits_seen, sb.misses_seen);
        $display("directed edges, ties and saturation, then four sender idle phases");
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
